// ===== src/source_text_tokenizer_defines.svh =====
// ----------------------------------------------------------------------------
// Source text tokenizer: assertion macros
// Shared property forms for the tokenizer checks.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Types, token codes, character codes and keyword tables.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  kind_t;
  typedef logic [30:0] value_t;
  typedef logic [15:0] pos16_t;
  typedef logic [15:0] len_t;
  typedef logic [2:0]  err_t;

  // Token kinds.
  localparam kind_t KIND_WORD   = 5'd0;
  localparam kind_t KIND_NUMBER = 5'd1;
  localparam kind_t KIND_STRING = 5'd2;
  localparam kind_t KIND_KW0    = 5'd3;
  localparam kind_t KIND_PLUS   = 5'd11;
  localparam kind_t KIND_MINUS  = 5'd12;
  localparam kind_t KIND_SLASH  = 5'd13;
  localparam kind_t KIND_STAR   = 5'd14;
  localparam kind_t KIND_ASSIGN = 5'd15;
  localparam kind_t KIND_EQ     = 5'd16;
  localparam kind_t KIND_GT     = 5'd17;
  localparam kind_t KIND_GE     = 5'd18;
  localparam kind_t KIND_LT     = 5'd19;
  localparam kind_t KIND_LE     = 5'd20;
  localparam kind_t KIND_NE     = 5'd21;
  localparam kind_t KIND_SEMI   = 5'd22;
  localparam kind_t KIND_COLON  = 5'd23;
  localparam kind_t KIND_LPAREN = 5'd24;
  localparam kind_t KIND_RPAREN = 5'd25;

  // Error codes.
  localparam err_t ERR_NONE         = 3'd0;
  localparam err_t ERR_BANG         = 3'd1;
  localparam err_t ERR_UNTERMINATED = 3'd2;
  localparam err_t ERR_BADCHAR      = 3'd3;
  localparam err_t ERR_OVERFLOW     = 3'd4;

  // Character codes.
  localparam byte_t CH_PLUS   = 8'h2B;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_EQUAL  = 8'h3D;
  localparam byte_t CH_GREATER = 8'h3E;
  localparam byte_t CH_LESS   = 8'h3C;
  localparam byte_t CH_BANG   = 8'h21;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_LOW_A  = 8'h61;
  localparam byte_t CH_LOW_Z  = 8'h7A;
  localparam byte_t CH_UP_A   = 8'h41;
  localparam byte_t CH_UP_Z   = 8'h5A;

  localparam logic [34:0] VALUE_MAX = 35'h0_7FFF_FFFF;
  localparam len_t        LEN_MAX   = 16'hFFFF;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Keywords: var, print, input, true, false, none, if, else.
  localparam int KW_COUNT = 8;
  localparam int KW_CHARS = 5;
  localparam byte_t KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t"},
    '{"i", "n", "p", "u", "t"},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"},
    '{"n", "o", "n", "e", 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd2, 3'd4
  };

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_WORD     = 6'b000010,
    MODE_NUMBER   = 6'b000100,
    MODE_STRING   = 6'b001000,
    MODE_OPERATOR = 6'b010000,
    MODE_ERROR    = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    OP_EQUAL   = 2'd0,
    OP_GREATER = 2'd1,
    OP_LESS    = 2'd2,
    OP_BANG    = 2'd3
  } op_t;

  typedef struct packed {
    kind_t  kind;
    value_t number_value;
    pos16_t start_pos;
    len_t   text_length;
    err_t   error_code;
    logic   run_last;
  } res_t;

  function automatic res_t make_res(input kind_t kind, input value_t value,
                                    input pos16_t start, input len_t len,
                                    input err_t err);
    res_t r;
    r.kind         = kind;
    r.number_value = value;
    r.start_pos    = start;
    r.text_length  = len;
    r.error_code   = err;
    r.run_last     = 1'b0;
    return r;
  endfunction

  function automatic len_t sat_inc(input len_t len);
    return (len == LEN_MAX) ? len : len + 16'd1;
  endfunction

  // Drop every keyword that cannot match once letter c lands at offset len.
  function automatic logic [KW_COUNT-1:0] kw_next(input logic [KW_COUNT-1:0] mask,
                                                  input len_t len, input byte_t c);
    logic [KW_COUNT-1:0] m;
    m = mask;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len >= 16'(KW_LEN[i])) begin
        m[i] = 1'b0;
      end else if (KW_TEXT[i][len[2:0]] != c) begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic kind_t kw_kind(input logic [KW_COUNT-1:0] mask, input len_t len);
    kind_t k;
    k = KIND_WORD;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (mask[i] && (len == 16'(KW_LEN[i]))) begin
        k = 5'(int'(KIND_KW0) + i);
      end
    end
    return k;
  endfunction

  function automatic kind_t op_double(input op_t op);
    kind_t k;
    unique case (op)
      OP_EQUAL:   k = KIND_EQ;
      OP_GREATER: k = KIND_GE;
      OP_LESS:    k = KIND_LE;
      OP_BANG:    k = KIND_NE;
      default:    k = KIND_WORD;
    endcase
    return k;
  endfunction

  function automatic kind_t op_single(input op_t op);
    kind_t k;
    unique case (op)
      OP_EQUAL:   k = KIND_ASSIGN;
      OP_GREATER: k = KIND_GT;
      OP_LESS:    k = KIND_LT;
      default:    k = KIND_WORD;
    endcase
    return k;
  endfunction

endpackage

// ===== src/stt_byte_if.sv =====
// ----------------------------------------------------------------------------
// Source byte channel
// Valid/ready channel carrying one source byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface stt_byte_if;
  import stt_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_in;
  logic  final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

// ===== src/stt_token_if.sv =====
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one token or error word.
// ----------------------------------------------------------------------------
interface stt_token_if;
  import stt_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  value_t number_value;
  pos16_t start_pos;
  len_t   text_length;
  err_t   error_code;
  logic   run_last;

  modport source (output valid, output kind, output number_value, output start_pos,
                  output text_length, output error_code, output run_last, input ready);
  modport sink   (input valid, input kind, input number_value, input start_pos,
                  input text_length, input error_code, input run_last, output ready);
endinterface

// ===== src/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer
// Byte-serial lexical scanner: words, keywords, numbers, strings, operators.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word contents
//  byte_ch    in         byte_in, final_byte
//  token_ch   out        kind, number_value, start_pos, text_length,
//                        error_code, run_last
//
// One source byte is scanned per cycle while byte_ch is ready; the scanner state updates in the cycle
// the byte is taken and its tokens land in a four-entry result queue.
// A byte that ends one token and completes another gives two words, which
// leave on token_ch in stream order; byte_ch stays ready while two entries are free.
// Reset is synchronous and returns the scanner to idle at position zero.
// A stall on token_ch fills the queue and then holds byte_ch off.
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer #(
  parameter int POSITION_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  stt_byte_if.sink   byte_ch,
  stt_token_if.source token_ch
);
  import stt_pkg::*;

  typedef logic [POSITION_WIDTH-1:0] pos_t;

  // Scanner state.
  mode_t               mode, mode_next;
  op_t                 pend, pend_next;
  value_t              acc, acc_next;
  logic [KW_COUNT-1:0] mask, mask_next;
  pos_t                tok_start, start_next;
  len_t                tok_len, len_next;
  pos_t                byte_pos, pos_next;

  // Result queue.
  res_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  logic        accept, pop;
  byte_t       c;
  logic        c_digit, c_alpha, c_final;
  logic [34:0] num_sum;
  logic        consumed;
  logic        v_mode, v_start, v_last;
  res_t        e_mode, e_start, e_last;
  res_t        r0, r1;
  logic [1:0]  res_cnt, push_cnt;

  assign c       = byte_ch.byte_in;
  assign c_final = byte_ch.final_byte;
  assign c_digit = (c >= CH_0) && (c <= CH_9);
  assign c_alpha = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  assign num_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, 4'(c - CH_0)};

  assign byte_ch.ready = (fill <= QCNT_W'(QUEUE_DEPTH - 2));
  assign accept        = byte_ch.valid && byte_ch.ready;

  always_comb begin
    mode_next  = mode;
    pend_next  = pend;
    acc_next   = acc;
    mask_next  = mask;
    start_next = tok_start;
    len_next   = tok_len;
    pos_next   = byte_pos + pos_t'(1);
    consumed   = 1'b0;
    v_mode     = 1'b0;
    v_start    = 1'b0;
    v_last     = 1'b0;
    e_mode     = '0;
    e_start    = '0;
    e_last     = '0;

    // Continue or close the token in progress.
    unique case (mode)
      MODE_WORD: begin
        if (c_alpha) begin
          mask_next = kw_next(mask, tok_len, c);
          len_next  = sat_inc(tok_len);
          consumed  = 1'b1;
        end else begin
          v_mode    = 1'b1;
          e_mode    = make_res(kw_kind(mask, tok_len), '0, 16'(tok_start), tok_len, ERR_NONE);
          mode_next = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (c_digit) begin
          consumed = 1'b1;
          if (num_sum > VALUE_MAX) begin
            v_mode    = 1'b1;
            e_mode    = make_res(KIND_WORD, '0, 16'(tok_start), '0, ERR_OVERFLOW);
            mode_next = MODE_ERROR;
          end else begin
            acc_next = num_sum[30:0];
            len_next = sat_inc(tok_len);
          end
        end else begin
          v_mode    = 1'b1;
          e_mode    = make_res(KIND_NUMBER, acc, 16'(tok_start), tok_len, ERR_NONE);
          mode_next = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        consumed = 1'b1;
        if (c == CH_QUOTE) begin
          v_mode    = 1'b1;
          e_mode    = make_res(KIND_STRING, '0, 16'(tok_start), tok_len, ERR_NONE);
          mode_next = MODE_IDLE;
        end else begin
          len_next = sat_inc(tok_len);
        end
      end
      MODE_OPERATOR: begin
        if (c == CH_EQUAL) begin
          v_mode    = 1'b1;
          e_mode    = make_res(op_double(pend), '0, 16'(tok_start), 16'd2, ERR_NONE);
          mode_next = MODE_IDLE;
          consumed  = 1'b1;
        end else if (pend == OP_BANG) begin
          v_mode    = 1'b1;
          e_mode    = make_res(KIND_WORD, '0, 16'(tok_start), '0, ERR_BANG);
          mode_next = MODE_ERROR;
          consumed  = 1'b1;
        end else begin
          v_mode    = 1'b1;
          e_mode    = make_res(op_single(pend), '0, 16'(tok_start), 16'd1, ERR_NONE);
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
      end
      MODE_ERROR: begin
        consumed = 1'b1;
      end
      default: begin
        consumed = 1'b1;
      end
    endcase

    // A byte not taken by the previous token may open a new one.
    if (!consumed && (mode_next == MODE_IDLE)) begin
      case (c) inside
        CH_PLUS:   begin v_start = 1'b1; e_start.kind = KIND_PLUS;   end
        CH_MINUS:  begin v_start = 1'b1; e_start.kind = KIND_MINUS;  end
        CH_SLASH:  begin v_start = 1'b1; e_start.kind = KIND_SLASH;  end
        CH_STAR:   begin v_start = 1'b1; e_start.kind = KIND_STAR;   end
        CH_SEMI:   begin v_start = 1'b1; e_start.kind = KIND_SEMI;   end
        CH_COLON:  begin v_start = 1'b1; e_start.kind = KIND_COLON;  end
        CH_LPAREN: begin v_start = 1'b1; e_start.kind = KIND_LPAREN; end
        CH_RPAREN: begin v_start = 1'b1; e_start.kind = KIND_RPAREN; end
        CH_EQUAL, CH_GREATER, CH_LESS, CH_BANG: begin
          unique case (c)
            CH_EQUAL:   pend_next = OP_EQUAL;
            CH_GREATER: pend_next = OP_GREATER;
            CH_LESS:    pend_next = OP_LESS;
            default:    pend_next = OP_BANG;
          endcase
          mode_next  = MODE_OPERATOR;
          start_next = byte_pos;
        end
        CH_SPACE, CH_NEWLINE: begin
        end
        CH_QUOTE: begin
          mode_next  = MODE_STRING;
          start_next = byte_pos + pos_t'(1);
          len_next   = '0;
        end
        [CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]: begin
          mode_next  = MODE_WORD;
          start_next = byte_pos;
          mask_next  = kw_next({KW_COUNT{1'b1}}, '0, c);
          len_next   = 16'd1;
        end
        [CH_0:CH_9]: begin
          mode_next  = MODE_NUMBER;
          start_next = byte_pos;
          len_next   = 16'd1;
          acc_next   = 31'(c - CH_0);
        end
        default: begin
          v_start   = 1'b1;
          e_start   = make_res(KIND_WORD, '0, 16'(byte_pos), '0, ERR_BADCHAR);
          mode_next = MODE_ERROR;
        end
      endcase
      // Single-character operators share position and length.
      if (v_start && (e_start.error_code == ERR_NONE)) begin
        e_start.start_pos   = 16'(byte_pos);
        e_start.text_length = 16'd1;
      end
    end

    // The final byte flushes whatever is pending and rewinds the scanner.
    if (c_final) begin
      unique case (mode_next)
        MODE_WORD: begin
          v_last = 1'b1;
          e_last = make_res(kw_kind(mask_next, len_next), '0, 16'(start_next), len_next,
                            ERR_NONE);
        end
        MODE_NUMBER: begin
          v_last = 1'b1;
          e_last = make_res(KIND_NUMBER, acc_next, 16'(start_next), len_next, ERR_NONE);
        end
        MODE_STRING: begin
          v_last = 1'b1;
          e_last = make_res(KIND_WORD, '0, 16'(start_next), '0, ERR_UNTERMINATED);
        end
        MODE_OPERATOR: begin
          v_last = 1'b1;
          if (pend_next == OP_BANG) begin
            e_last = make_res(KIND_WORD, '0, 16'(start_next), '0, ERR_BANG);
          end else begin
            e_last = make_res(op_single(pend_next), '0, 16'(start_next), 16'd1, ERR_NONE);
          end
        end
        default: begin
        end
      endcase
      mode_next  = MODE_IDLE;
      pend_next  = OP_EQUAL;
      acc_next   = '0;
      mask_next  = {KW_COUNT{1'b1}};
      start_next = '0;
      len_next   = '0;
      pos_next   = '0;
    end
  end

  // Pack up to two results in stream order; the last one carries run_last.
  always_comb begin
    res_cnt = 2'(v_mode) + 2'(v_start) + 2'(v_last);
    if (res_cnt > 2'd2) begin
      res_cnt = 2'd2;
    end
    r0 = v_mode ? e_mode : (v_start ? e_start : e_last);
    r1 = (v_mode && v_start) ? e_start : e_last;
    r0.run_last = (res_cnt == 2'd1);
    r1.run_last = 1'b1;
  end

  assign push_cnt = accept ? res_cnt : 2'd0;
  assign pop      = token_ch.valid && token_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pend      <= OP_EQUAL;
      acc       <= '0;
      mask      <= {KW_COUNT{1'b1}};
      tok_start <= '0;
      tok_len   <= '0;
      byte_pos  <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      pend      <= pend_next;
      acc       <= acc_next;
      mask      <= mask_next;
      tok_start <= start_next;
      tok_len   <= len_next;
      byte_pos  <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_cnt);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      fill   <= fill + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= r0;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= r1;
    end
  end

  assign token_ch.valid        = (fill != '0);
  assign token_ch.kind         = queue[rd_ptr].kind;
  assign token_ch.number_value = queue[rd_ptr].number_value;
  assign token_ch.start_pos    = queue[rd_ptr].start_pos;
  assign token_ch.text_length  = queue[rd_ptr].text_length;
  assign token_ch.error_code   = queue[rd_ptr].error_code;
  assign token_ch.run_last     = queue[rd_ptr].run_last;

  `STT_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, fill <= QCNT_W'(QUEUE_DEPTH), "result queue overrun")
  `STT_ASSERT_NOW(a_error_silent, clk, rst, accept && (mode == MODE_ERROR), push_cnt == 2'd0, "word emitted while skipping after an error")
  `STT_ASSERT_NEXT(a_final_rewind, clk, rst, accept && c_final, (mode == MODE_IDLE) && (byte_pos == '0), "scanner not rewound after last byte")

endmodule

// ===== tb/source_text_tokenizer_checker.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer checker
// Watches both channels and predicts the token words for every byte taken.
// Each word that leaves the block is compared field by field with the oldest
// predicted word. The predictor keeps its own scanner state, and the number of
// failures and the number of words still owed go to the testbench top.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker (
  input  logic clk,
  input  logic rst,
  stt_byte_if  byte_ch,
  stt_token_if token_ch,
  output int   fail_count,
  output int   words_pending,
  output int   words_checked,
  output int   errors_seen
);
  import stt_pkg::*;

  mode_t       scan_mode;
  op_t         held_op;
  logic [31:0] acc;
  logic [7:0]  kw_live;
  pos16_t      tok_start;
  len_t        tok_len;
  pos16_t      next_pos;

  res_t step_words[$];
  res_t token_queue[$];
  int   fails;
  int   checked;
  int   err_words;

  function automatic logic is_letter(input byte_t c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= CH_0 && c <= CH_9);
  endfunction

  function automatic len_t bump(input len_t n);
    return (n == LEN_MAX) ? n : n + 16'd1;
  endfunction

  // One byte never gives more than two words.
  function automatic void post(input kind_t k, input value_t v, input pos16_t s,
                               input len_t l, input err_t e);
    res_t w;
    if (step_words.size() < 2) begin
      w.kind         = k;
      w.number_value = v;
      w.start_pos    = s;
      w.text_length  = l;
      w.error_code   = e;
      w.run_last     = 1'b0;
      step_words.insert(step_words.size(), w);
    end
  endfunction

  function automatic void fail(input err_t e, input pos16_t s);
    post(KIND_WORD, '0, s, '0, e);
    scan_mode = MODE_ERROR;
  endfunction

  function automatic void reset_scan();
    scan_mode = MODE_IDLE;
    held_op   = OP_EQUAL;
    acc       = '0;
    kw_live   = 8'hFF;
    tok_start = '0;
    tok_len   = '0;
    next_pos  = '0;
  endfunction

  // A keyword stays live only while every letter so far matches its spelling.
  function automatic void take_letter(input byte_t c);
    for (int i = 0; i < KW_COUNT; i++) begin
      if (tok_len >= len_t'(KW_LEN[i])) begin
        kw_live[i] = 1'b0;
      end else if (KW_TEXT[i][tok_len[2:0]] != c) begin
        kw_live[i] = 1'b0;
      end
    end
    tok_len = bump(tok_len);
  endfunction

  function automatic kind_t word_kind();
    kind_t k;
    k = KIND_WORD;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (kw_live[i] && tok_len == len_t'(KW_LEN[i])) begin
        k = kind_t'(int'(KIND_KW0) + i);
      end
    end
    return k;
  endfunction

  function automatic kind_t single_kind(input op_t op);
    case (op)
      OP_EQUAL:   return KIND_ASSIGN;
      OP_GREATER: return KIND_GT;
      OP_LESS:    return KIND_LT;
      default:    return KIND_WORD;
    endcase
  endfunction

  function automatic kind_t double_kind(input op_t op);
    case (op)
      OP_EQUAL:   return KIND_EQ;
      OP_GREATER: return KIND_GE;
      OP_LESS:    return KIND_LE;
      default:    return KIND_NE;
    endcase
  endfunction

  function automatic void hold_op(input op_t op, input pos16_t here);
    held_op   = op;
    scan_mode = MODE_OPERATOR;
    tok_start = here;
  endfunction

  function automatic void open_token(input byte_t c, input pos16_t here);
    case (c)
      CH_PLUS:    post(KIND_PLUS, '0, here, 16'd1, ERR_NONE);
      CH_MINUS:   post(KIND_MINUS, '0, here, 16'd1, ERR_NONE);
      CH_SLASH:   post(KIND_SLASH, '0, here, 16'd1, ERR_NONE);
      CH_STAR:    post(KIND_STAR, '0, here, 16'd1, ERR_NONE);
      CH_SEMI:    post(KIND_SEMI, '0, here, 16'd1, ERR_NONE);
      CH_COLON:   post(KIND_COLON, '0, here, 16'd1, ERR_NONE);
      CH_LPAREN:  post(KIND_LPAREN, '0, here, 16'd1, ERR_NONE);
      CH_RPAREN:  post(KIND_RPAREN, '0, here, 16'd1, ERR_NONE);
      CH_EQUAL:   hold_op(OP_EQUAL, here);
      CH_GREATER: hold_op(OP_GREATER, here);
      CH_LESS:    hold_op(OP_LESS, here);
      CH_BANG:    hold_op(OP_BANG, here);
      CH_SPACE, CH_NEWLINE: ;
      CH_QUOTE: begin
        // String text starts after the opening quote.
        scan_mode = MODE_STRING;
        tok_start = here + 16'd1;
        tok_len   = '0;
      end
      default: begin
        if (is_letter(c)) begin
          scan_mode = MODE_WORD;
          tok_start = here;
          tok_len   = '0;
          kw_live   = 8'hFF;
          take_letter(c);
        end else if (is_digit(c)) begin
          scan_mode = MODE_NUMBER;
          tok_start = here;
          tok_len   = 16'd1;
          acc       = 32'(c - CH_0);
        end else begin
          fail(ERR_BADCHAR, here);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(input byte_t c, input logic last);
    logic        used;
    pos16_t      here;
    logic [35:0] grown;
    here = next_pos;
    used = 1'b0;
    step_words.delete();
    case (scan_mode)
      MODE_WORD: begin
        if (is_letter(c)) begin
          take_letter(c);
          used = 1'b1;
        end else begin
          post(word_kind(), '0, tok_start, tok_len, ERR_NONE);
          scan_mode = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          used  = 1'b1;
          grown = {4'd0, acc} * 36'd10 + 36'(c - CH_0);
          if (grown > 36'h0_7FFF_FFFF) begin
            fail(ERR_OVERFLOW, tok_start);
          end else begin
            acc     = grown[31:0];
            tok_len = bump(tok_len);
          end
        end else begin
          post(KIND_NUMBER, acc[30:0], tok_start, tok_len, ERR_NONE);
          scan_mode = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        used = 1'b1;
        if (c == CH_QUOTE) begin
          post(KIND_STRING, '0, tok_start, tok_len, ERR_NONE);
          scan_mode = MODE_IDLE;
        end else begin
          tok_len = bump(tok_len);
        end
      end
      MODE_OPERATOR: begin
        if (c == CH_EQUAL) begin
          post(double_kind(held_op), '0, tok_start, 16'd2, ERR_NONE);
          scan_mode = MODE_IDLE;
          used      = 1'b1;
        end else if (held_op == OP_BANG) begin
          // The byte after a lone bang is swallowed by the error.
          fail(ERR_BANG, tok_start);
          used = 1'b1;
        end else begin
          post(single_kind(held_op), '0, tok_start, 16'd1, ERR_NONE);
          scan_mode = MODE_IDLE;
        end
      end
      MODE_IDLE: ;
      default: used = 1'b1;
    endcase
    if (!used && scan_mode == MODE_IDLE) begin
      open_token(c, here);
    end
    next_pos = here + 16'd1;

    if (last) begin
      case (scan_mode)
        MODE_WORD:   post(word_kind(), '0, tok_start, tok_len, ERR_NONE);
        MODE_NUMBER: post(KIND_NUMBER, acc[30:0], tok_start, tok_len, ERR_NONE);
        MODE_STRING: fail(ERR_UNTERMINATED, tok_start);
        MODE_OPERATOR: begin
          if (held_op == OP_BANG) begin
            fail(ERR_BANG, tok_start);
          end else begin
            post(single_kind(held_op), '0, tok_start, 16'd1, ERR_NONE);
          end
        end
        default: ;
      endcase
      reset_scan();
    end

    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].run_last = 1'b1;
    end
    foreach (step_words[i]) begin
      token_queue.insert(token_queue.size(), step_words[i]);
    end
  endfunction

  function automatic void check_word();
    res_t want;
    logic bad;
    bad = 1'b0;
    if (token_queue.size() == 0) begin
      $error("token word with nothing expected: kind %0d start_pos %0d",
             token_ch.kind, token_ch.start_pos);
      fails++;
      return;
    end
    want = token_queue.pop_front();
    if (token_ch.kind != want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, token_ch.kind);
      bad = 1'b1;
    end
    if (token_ch.number_value != want.number_value) begin
      $error("number_value: expected %0d, actual %0d", want.number_value,
             token_ch.number_value);
      bad = 1'b1;
    end
    if (token_ch.start_pos != want.start_pos) begin
      $error("start_pos: expected %0d, actual %0d", want.start_pos, token_ch.start_pos);
      bad = 1'b1;
    end
    if (token_ch.text_length != want.text_length) begin
      $error("text_length: expected %0d, actual %0d", want.text_length,
             token_ch.text_length);
      bad = 1'b1;
    end
    if (token_ch.error_code != want.error_code) begin
      $error("error_code: expected %0d, actual %0d", want.error_code, token_ch.error_code);
      bad = 1'b1;
    end
    if (token_ch.run_last != want.run_last) begin
      $error("run_last: expected %0d, actual %0d", want.run_last, token_ch.run_last);
      bad = 1'b1;
    end
    if (bad) begin
      fails++;
    end
    checked++;
    if (want.error_code != ERR_NONE) begin
      err_words++;
    end
  endfunction

  // The byte is predicted before the word is checked, so a word that left in
  // the same cycle as its byte would still find its expectation.
  always @(posedge clk) begin
    if (rst) begin
      reset_scan();
      token_queue.delete();
      fails     = 0;
      checked   = 0;
      err_words = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        scan_byte(byte_ch.byte_in, byte_ch.final_byte);
      end
      if (token_ch.valid && token_ch.ready) begin
        check_word();
      end
    end
    fail_count    <= fails;
    words_pending <= token_queue.size();
    words_checked <= checked;
    errors_seen   <= err_words;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds byte streams to the tokenizer under varying sender and receiver stalls.
// A short directed part is followed by random streams, mostly well-formed
// token sequences and partly noise and broken input. The checker predicts and
// compares.
// ----------------------------------------------------------------------------
module tb;
  import stt_pkg::*;

  logic  clk;
  logic  rst;
  int    src_idle;
  int    snk_idle;
  int    fail_count;
  int    words_pending;
  int    words_checked;
  int    errors_seen;
  int    random_bytes;
  int    bytes_sent;
  int    streams_sent;
  byte_t stream[$];

  stt_byte_if  byte_bus ();
  stt_token_if token_bus ();

  source_text_tokenizer #(
    .POSITION_WIDTH(16)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_bus),
    .token_ch(token_bus)
  );

  source_text_tokenizer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_ch      (byte_bus),
    .token_ch     (token_bus),
    .fail_count   (fail_count),
    .words_pending(words_pending),
    .words_checked(words_checked),
    .errors_seen  (errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    token_bus.ready <= ($urandom_range(99) >= snk_idle);
  end

  function automatic logic known_char(input byte_t c);
    case (c)
      CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_SEMI, CH_COLON, CH_LPAREN, CH_RPAREN,
      CH_EQUAL, CH_GREATER, CH_LESS, CH_BANG, CH_SPACE, CH_NEWLINE, CH_QUOTE:
        return 1'b1;
      default:
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LOW_A && c <= CH_LOW_Z) ||
               (c >= CH_UP_A && c <= CH_UP_Z);
    endcase
  endfunction

  task automatic send_byte(input byte_t c, input logic last);
    while ($urandom_range(99) < src_idle) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.byte_in    <= c;
    byte_bus.final_byte <= last;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
  endtask

  task automatic send_stream();
    foreach (stream[i]) begin
      send_byte(stream[i], i == stream.size() - 1);
    end
    bytes_sent += stream.size();
    streams_sent++;
    stream.delete();
  endtask

  task automatic add_byte(input byte_t c);
    stream.insert(stream.size(), c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(byte_t'(s[i]));
    end
  endtask

  task automatic add_run(input byte_t c, input int n);
    repeat (n) add_byte(c);
  endtask

  task automatic add_letter();
    if ($urandom_range(1)) begin
      add_byte(byte_t'(CH_LOW_A + $urandom_range(25)));
    end else begin
      add_byte(byte_t'(CH_UP_A + $urandom_range(25)));
    end
  endtask

  task automatic add_digits(input int n);
    repeat (n) add_byte(byte_t'(CH_0 + $urandom_range(9)));
  endtask

  task automatic add_gap();
    int g;
    g = $urandom_range(3);
    if (g != 0) begin
      repeat ($urandom_range(1, 2)) begin
        add_byte($urandom_range(1) ? CH_SPACE : CH_NEWLINE);
      end
    end
  endtask

  task automatic add_token();
    int    k;
    int    n;
    byte_t c;
    byte_t op_first [4];
    byte_t op_alone [11];
    op_first = '{CH_EQUAL, CH_GREATER, CH_LESS, CH_BANG};
    op_alone = '{CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_SEMI, CH_COLON, CH_LPAREN,
                 CH_RPAREN, CH_EQUAL, CH_GREATER, CH_LESS};
    case ($urandom_range(5))
      0: begin
        k = $urandom_range(KW_COUNT - 1);
        for (int j = 0; j < int'(KW_LEN[k]); j++) add_byte(KW_TEXT[k][j]);
      end
      1: begin
        // Keyword prefix, possibly grown past the keyword.
        k = $urandom_range(KW_COUNT - 1);
        n = $urandom_range(1, int'(KW_LEN[k]));
        for (int j = 0; j < n; j++) add_byte(KW_TEXT[k][j]);
        repeat ($urandom_range(2)) add_letter();
      end
      2: repeat ($urandom_range(1, 6)) add_letter();
      3: begin
        case ($urandom_range(4))
          0: add_digits($urandom_range(1, 3));
          1: begin
            add_byte($urandom_range(1) ? byte_t'("1") : byte_t'("2"));
            add_digits(9);
          end
          2: add_digits(11);
          3: begin
            add_run(CH_0, $urandom_range(1, 3));
            add_digits($urandom_range(1, 2));
          end
          default: begin
            add_text("214748364");
            add_byte(byte_t'("7" + $urandom_range(2)));
          end
        endcase
      end
      4: begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(5)) begin
          c = byte_t'($urandom_range(255));
          add_byte((c == CH_QUOTE) ? CH_LOW_A : c);
        end
        add_byte(CH_QUOTE);
      end
      default: begin
        n = $urandom_range(14);
        if (n < 11) begin
          add_byte(op_alone[n]);
        end else begin
          add_byte(op_first[n - 11]);
          add_byte(CH_EQUAL);
        end
      end
    endcase
  endtask

  task automatic add_tokens(input int n);
    repeat (n) begin
      add_token();
      add_gap();
    end
  endtask

  // Broken streams mostly carry a fault; whatever follows the first fault must be ignored.
  task automatic build_broken();
    byte_t c;
    case ($urandom_range(4))
      0: repeat ($urandom_range(1, 6)) add_byte(byte_t'($urandom_range(255)));
      1: begin
        add_tokens($urandom_range(3));
        add_byte(CH_BANG);
        if ($urandom_range(3) != 0) begin
          c = byte_t'($urandom_range(255));
          add_byte((c == CH_EQUAL) ? CH_SPACE : c);
          add_tokens($urandom_range(2));
        end
      end
      2: begin
        add_tokens($urandom_range(3));
        add_byte(CH_QUOTE);
        repeat ($urandom_range(4)) add_letter();
      end
      3: begin
        add_tokens($urandom_range(3));
        do c = byte_t'($urandom_range(255)); while (known_char(c));
        add_byte(c);
        add_tokens($urandom_range(2));
      end
      default: begin
        add_tokens($urandom_range(3));
        add_byte(byte_t'("3"));
        add_digits($urandom_range(10, 11));
        add_tokens($urandom_range(2));
      end
    endcase
  endtask

  initial begin
    rst                 <= 1'b1;
    byte_bus.valid      <= 1'b0;
    byte_bus.byte_in    <= '0;
    byte_bus.final_byte <= 1'b0;
    src_idle     = 21;
    snk_idle     = 50;
    random_bytes = 0;
    bytes_sent   = 0;
    streams_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: largest number, lone bang, unterminated string, bad bytes at
    // both ends of the range, two-character operators, keyword then operator.
    add_text("2147483647");
    send_stream();
    add_text("!x");
    send_stream();
    add_text("\"ab");
    send_stream();
    add_byte(8'hFF);
    send_stream();
    add_text("<=!=");
    send_stream();
    add_byte(8'h00);
    send_stream();
    add_text("else+");
    send_stream();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 21 : (ph == 1) ? 50 : 0;
      snk_idle = (ph == 0) ? 50 : (ph == 1) ? 21 : 0;
      while (random_bytes < (ph + 1) * 370) begin
        if ($urandom_range(9) < 8) begin
          add_tokens($urandom_range(1, 8));
        end else begin
          build_broken();
        end
        random_bytes += stream.size();
        send_stream();
      end
    end

    byte_bus.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d streams; checked %0d token words, %0d of them errors.",
             bytes_sent, streams_sent, words_checked, errors_seen);
    $display("Stalls varied on both sides, from heavy sender idling to none at all.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
